/* rtl/vl2n_pkg.sv */
// Shared constants for the vector L2 normalisation block.
`default_nettype none

package vl2n_pkg;

	localparam int ELEM_W  = 16;
	localparam int Q_FRAC  = 14;
	localparam int Q_W     = Q_FRAC + 1;
	localparam int BIT_W   = 4;
	localparam int MSQ_W   = 2 * ELEM_W - 1;
	localparam int RHS_SH  = 2 * Q_FRAC + 2;

endpackage

`default_nettype wire

/* rtl/vector_l2_normalize.sv */
// Top level of the vector L2 normalisation block.
`default_nettype none

// Components arrive one per input transaction and are written to an element
// memory while the sum of their squares is accumulated; s_tready stays low
// while each square is added to the sum. The transaction marked tlast, or the
// one that fills the memory to MAX_LEN entries, closes the vector. Each stored
// component is then read back and its correctly rounded Q2.14 quotient by the
// norm is found one bit at a time, from bit 14 down, by exact comparison of
// squares; every bit trial squares the odd trial value, multiplies it by the
// sum and compares, and the trials are skipped when the vector or the
// component is zero. A result waits in the output register while the next one
// is computed, and the final result carries tlast.
module vector_l2_normalize #(
	parameter int MAX_LEN = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [vl2n_pkg::ELEM_W-1:0]   s_tdata,   // element[15:0]
	input  wire logic                          s_tlast,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [vl2n_pkg::ELEM_W-1:0]        m_tdata,   // normalized[15:0]
	output logic                               m_tlast,
	output logic                               m_tuser    // zero_vector
);

	import vl2n_pkg::*;

	localparam int CNT_W  = $clog2(MAX_LEN + 1);
	localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int SUM_W  = MSQ_W + $clog2(MAX_LEN);
	localparam int SUM_PW = (SUM_W > 32) ? SUM_W : 33;
	localparam int HI_W   = SUM_PW - 32;
	localparam int PROD_W = SUM_PW + 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_READ,
		ST_SQR,
		ST_ODD,
		ST_MUL,
		ST_CMP,
		ST_OUT
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        idx_q;
	logic                    close_q;
	logic [SUM_W-1:0]        sum_q;
	logic [MSQ_W-1:0]        sq_s1;
	logic [ELEM_W-1:0]       rd_data_q;
	logic [MSQ_W-1:0]        msq_q;
	logic                    neg_q;
	logic                    zero_q;
	logic [Q_W-1:0]          q_q;
	logic [BIT_W-1:0]        bit_q;
	logic [31:0]             odd_sq_s2;
	logic [63:0]             p_lo_s3;
	logic [31+HI_W:0]        p_hi_s3;
	logic                    m_tvalid_q;
	logic [ELEM_W-1:0]       m_tdata_q;
	logic                    m_tlast_q;
	logic                    m_tuser_q;

	logic [ELEM_W-1:0]       mem [MAX_LEN];

	logic                    in_acc;
	logic signed [ELEM_W-1:0] in_x;
	logic signed [2*ELEM_W-1:0] in_sq;
	logic signed [ELEM_W-1:0] rd_x;
	logic signed [2*ELEM_W-1:0] rd_sq;
	logic [Q_W-1:0]          mask;
	logic [ELEM_W-1:0]       odd;
	logic [SUM_PW-1:0]       sum_pw;
	logic [PROD_W-1:0]       prod_total;
	logic [PROD_W-1:0]       rhs;
	logic                    pass;
	logic                    out_free;
	logic [CNT_W-1:0]        cnt_inc;

	assign s_tready   = (state_q == ST_IDLE);
	assign in_acc     = s_tvalid && s_tready;
	assign in_x       = s_tdata;
	assign in_sq      = in_x * in_x;
	assign rd_x       = rd_data_q;
	assign rd_sq      = rd_x * rd_x;
	assign mask       = ~({Q_W{1'b1}} << bit_q);
	assign odd        = {q_q | mask, 1'b1};
	assign sum_pw     = SUM_PW'(sum_q);
	assign prod_total = {p_hi_s3, 32'b0} + PROD_W'(p_lo_s3);
	assign rhs        = PROD_W'({msq_q, {RHS_SH{1'b0}}});
	assign pass       = (prod_total <= rhs);
	assign out_free   = !m_tvalid_q || m_tready;
	assign cnt_inc    = CNT_W'(cnt_q + 1'b1);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mem[cnt_q[AW-1:0]] <= s_tdata;
		end
		rd_data_q <= mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			close_q    <= 1'b0;
			sum_q      <= '0;
			sq_s1      <= '0;
			msq_q      <= '0;
			neg_q      <= 1'b0;
			zero_q     <= 1'b0;
			q_q        <= '0;
			bit_q      <= '0;
			odd_sq_s2  <= '0;
			p_lo_s3    <= '0;
			p_hi_s3    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sq_s1   <= in_sq[MSQ_W-1:0];
						cnt_q   <= cnt_inc;
						close_q <= s_tlast || (cnt_inc == CNT_W'(MAX_LEN));
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					sum_q <= sum_q + SUM_W'(sq_s1);
					idx_q <= '0;
					state_q <= close_q ? ST_READ : ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					msq_q   <= rd_sq[MSQ_W-1:0];
					neg_q   <= rd_data_q[ELEM_W-1];
					zero_q  <= (sum_q == '0);
					q_q     <= '0;
					bit_q   <= BIT_W'(Q_W - 1);
					state_q <= ((sum_q == '0) || (rd_data_q == '0)) ? ST_OUT : ST_ODD;
				end
				ST_ODD: begin
					odd_sq_s2 <= odd * odd;
					state_q   <= ST_MUL;
				end
				ST_MUL: begin
					p_lo_s3 <= odd_sq_s2 * sum_pw[31:0];
					p_hi_s3 <= odd_sq_s2 * sum_pw[SUM_PW-1:32];
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (pass) begin
						q_q[bit_q] <= 1'b1;
					end
					bit_q   <= bit_q - 1'b1;
					state_q <= (bit_q == '0) ? ST_OUT : ST_ODD;
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= neg_q ? ELEM_W'(16'd0 - ELEM_W'(q_q)) : ELEM_W'(q_q);
						m_tlast_q  <= (idx_q == CNT_W'(cnt_q - 1'b1));
						m_tuser_q  <= zero_q;
						if (idx_q == CNT_W'(cnt_q - 1'b1)) begin
							cnt_q   <= '0;
							sum_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= CNT_W'(idx_q + 1'b1);
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_zero_flag_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("zero vector flag with non-zero data");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata) <= 16384) && ($signed(m_tdata) >= -16384))
		else $error("normalised value out of Q2.14 range");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_LEN))
		else $error("element count beyond memory depth");

	a_close_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input accepted while a closed vector is being processed");

endmodule

`default_nettype wire
